// File: design/vta_pkg.sv
// vta_pkg: shared widths, request codes and controller/datapath interface structs
// for the vertex tangent accumulator. No dependencies.
package vta_pkg;

    localparam int IDX_W   = 10;   // vertex index port width
    localparam int POS_W   = 32;   // Q16.16 position
    localparam int UV_W    = 16;   // Q2.14 texture coordinate
    localparam int ACC_W   = 48;   // Q31.16 accumulator
    localparam int TAN_W   = 16;   // Q1.14 normalized tangent
    localparam int DP_W    = 33;   // position delta
    localparam int DUV_W   = 17;   // UV delta
    localparam int PRD_W   = 50;   // delta product
    localparam int NUM_W   = 51;   // difference of two products
    localparam int DIV_NW  = 64;   // divider dividend / quotient width
    localparam int DIV_DW  = 34;   // divider divisor width
    localparam int SQ_W    = 64;   // sum of squares
    localparam int ROOT_W  = 32;   // integer square root
    localparam int NRM_W   = 31;   // normalized magnitude, top bit at bit 30
    localparam int FRAC_SH = 14;   // Q.14 scaling shift

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TRI  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2,
        AX_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic       latch;
        logic       vm_we;
        logic [1:0] vm_sel;
        logic       vcap_en;
        logic [1:0] vcap_sel;
        logic       prod_en;
        logic       prod_det;
        logic       diff_en;
        logic       det_cap;
        t_axis      axis;
        logic       div_start;
        logic       div_norm;
        logic       t_cap;
        logic [1:0] corner;
        logic       am_we;
        logic       am_zero;
        logic       am_clr;
        logic       acc_cap;
        logic       norm_en;
        logic       sq_clr;
        logic       sq_en;
        logic       sqrt_start;
        logic       out_cap;
        logic       out_zero;
        logic       out_fire;
    } t_dp_cmd;

    typedef struct packed {
        logic ok_a;
        logic ok_all;
        logic clr_last;
        logic det_zero;
        logic div_done;
        logic sqrt_done;
        logic acc_zero;
        logic norm_ok;
    } t_dp_sts;

endpackage

// File: design/vertex_tangent_accumulator.sv
// vertex_tangent_accumulator: one transaction at a time; busy is high until it is done.
// Triangle: three passes around the 64-step serial divider, one per axis; it ends early
// on a zero determinant or when a corner is out of range.
// Read: normalize, square root, then three divides; it skips these for a zero accumulator;
// o_valid is high for one cycle and cannot be stalled.
// After reset the accumulators are zeroed, one entry a cycle, while busy is high.
module vertex_tangent_accumulator import vta_pkg::*; #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_req_type,
    input  logic [IDX_W-1:0]        i_vert_index,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [UV_W-1:0]  i_uv_u,
    input  logic signed [UV_W-1:0]  i_uv_v,
    input  logic [IDX_W-1:0]        i_corner_one,
    input  logic [IDX_W-1:0]        i_corner_two,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_out_index,
    output logic signed [TAN_W-1:0] o_tan_x,
    output logic signed [TAN_W-1:0] o_tan_y,
    output logic signed [TAN_W-1:0] o_tan_z,
    output logic                    o_zero_length
);
    // Depends on vta_pkg, vta_ctrl, vta_dpath.
    t_dp_cmd cmd;
    t_dp_sts sts;

    vta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    vta_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_vert_index  (i_vert_index),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_uv_u        (i_uv_u),
        .i_uv_v        (i_uv_v),
        .i_corner_one  (i_corner_one),
        .i_corner_two  (i_corner_two),
        .o_valid       (o_valid),
        .o_out_index   (o_out_index),
        .o_tan_x       (o_tan_x),
        .o_tan_y       (o_tan_y),
        .o_tan_z       (o_tan_z),
        .o_zero_length (o_zero_length)
    );

endmodule

// File: design/vta_div.sv
// vta_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on vta_pkg for operand widths.
module vta_div import vta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);
    localparam int CW = $clog2(DIV_NW);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_d;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW:0]   n_shift;
    logic [DIV_DW:0]   n_trial;

    assign n_shift = {r_rem, r_q[DIV_NW-1]};
    assign n_trial = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_q   <= i_dividend;
                r_d   <= i_divisor;
            end else if (r_run) begin
                // trial subtract is negative when the top bit is set
                r_rem <= n_trial[DIV_DW] ? n_shift[DIV_DW-1:0] : n_trial[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], ~n_trial[DIV_DW]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW-1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: design/vta_isqrt.sv
// vta_isqrt: bit-pair integer square root of a 64-bit value, one result bit per cycle.
// Depends on vta_pkg for widths.
module vta_isqrt import vta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_val,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);
    logic            r_run;
    logic            r_done;
    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] n_try;

    assign n_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_n   <= i_val;
                r_res <= '0;
                r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
            end else if (r_run) begin
                if (r_n >= n_try) begin
                    r_n   <= r_n - n_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// File: design/vta_dpath.sv
// vta_dpath: vertex and accumulator memories, delta multipliers, divider, square root
// and result registers. Depends on vta_pkg, vta_div and vta_isqrt.
module vta_dpath import vta_pkg::*; #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [IDX_W-1:0]        i_vert_index,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [UV_W-1:0]  i_uv_u,
    input  logic signed [UV_W-1:0]  i_uv_v,
    input  logic [IDX_W-1:0]        i_corner_one,
    input  logic [IDX_W-1:0]        i_corner_two,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_out_index,
    output logic signed [TAN_W-1:0] o_tan_x,
    output logic signed [TAN_W-1:0] o_tan_y,
    output logic signed [TAN_W-1:0] o_tan_z,
    output logic                    o_zero_length
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [16:0] NVERT = 17'(MAX_VERTICES);
    localparam int VW = 3*POS_W + 2*UV_W;
    localparam int AMW = 3*ACC_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // latched request
    logic [IDX_W-1:0] r_idx [3];
    logic [VW-1:0]    r_ld;
    logic             r_ok_a;
    logic             r_ok_all;
    logic [AW-1:0]    c_addr [3];
    logic [AW-1:0]    n_vm_ra;
    logic [AW-1:0]    n_am_a;

    // memories
    logic [VW-1:0]  vmem [MAX_VERTICES];
    logic [AMW-1:0] amem [MAX_VERTICES];
    logic [VW-1:0]  r_vrd;
    logic [AMW-1:0] r_ard;
    logic [AMW-1:0] n_am_wd;
    logic [AW-1:0]  r_clr_addr;

    // triangle arithmetic
    logic [VW-1:0]                r_v [3];
    logic signed [DUV_W-1:0]      n_du1, n_dv1, n_du2, n_dv2;
    logic signed [DP_W-1:0]       n_dp1, n_dp2;
    logic signed [DP_W-1:0]       n_ma, n_mb;
    logic signed [DUV_W-1:0]      n_mc, n_md;
    logic signed [PRD_W-1:0]      r_pa, r_pb;
    logic signed [NUM_W-1:0]      r_diff, r_det;
    logic [NUM_W-1:0]             n_num_abs, n_det_abs;
    logic                         r_qneg;
    logic signed [ACC_W-1:0]      r_t [3];
    logic [ACC_W-2:0]             n_qmag;
    logic signed [ACC_W-1:0]      n_tval;
    logic signed [ACC_W-1:0]      n_sum [3];

    // read arithmetic
    logic [ACC_W-1:0]   r_mag [3];
    logic               r_neg [3];
    logic [ACC_W-1:0]   n_mor;
    logic               n_hi, n_lo;
    logic [NRM_W-1:0]   n_sqm;
    logic [2*NRM_W-1:0] r_sqp;
    logic [SQ_W-1:0]    r_ssum;
    logic [ROOT_W-1:0]  n_len;
    logic               n_sqrt_done;

    // divider
    logic [DIV_NW-1:0] n_dvd;
    logic [DIV_DW-1:0] n_dvs;
    logic              n_div_done;
    logic [DIV_NW-1:0] n_quot;
    logic [TAN_W-1:0]  n_cval;

    // result
    logic                    r_valid;
    logic [IDX_W-1:0]        r_out_index;
    logic signed [TAN_W-1:0] r_tan [3];
    logic                    r_zl;

    function automatic logic [AW-1:0] pick3(input logic [1:0] sel, input logic [AW-1:0] a0,
                                            input logic [AW-1:0] a1, input logic [AW-1:0] a2);
        logic [AW-1:0] r;
        unique case (sel)
            2'd1:    r = a1;
            2'd2:    r = a2;
            default: r = a0;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] vpos(input logic [VW-1:0] v, input t_axis ax);
        logic signed [POS_W-1:0] r;
        unique case (ax)
            AX_X:    r = v[VW-1 -: POS_W];
            AX_Y:    r = v[VW-1-POS_W -: POS_W];
            default: r = v[VW-1-2*POS_W -: POS_W];
        endcase
        return r;
    endfunction

    function automatic logic signed [DUV_W-1:0] uvd(input logic signed [UV_W-1:0] b,
                                                    input logic signed [UV_W-1:0] a);
        return {b[UV_W-1], b} - {a[UV_W-1], a};
    endfunction

    function automatic logic signed [DP_W-1:0] pd(input logic signed [POS_W-1:0] b,
                                                  input logic signed [POS_W-1:0] a);
        return {b[POS_W-1], b} - {a[POS_W-1], a};
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    // ---------------- request latch ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx[0] <= i_vert_index;
            r_idx[1] <= i_corner_one;
            r_idx[2] <= i_corner_two;
            r_ld     <= {i_pos_x, i_pos_y, i_pos_z, i_uv_u, i_uv_v};
            r_ok_a   <= 17'(i_vert_index) < NVERT;
            r_ok_all <= (17'(i_vert_index) < NVERT) && (17'(i_corner_one) < NVERT)
                        && (17'(i_corner_two) < NVERT);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_addr[k] = AW'(r_idx[k]);
        end
    end

    assign n_vm_ra = pick3(i_cmd.vm_sel, c_addr[0], c_addr[1], c_addr[2]);
    assign n_am_a  = i_cmd.am_clr ? r_clr_addr
                                  : pick3(i_cmd.corner, c_addr[0], c_addr[1], c_addr[2]);

    // ---------------- vertex store ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.vm_we) begin
            vmem[c_addr[0]] <= r_ld;
        end
        r_vrd <= vmem[n_vm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vcap_en) begin
            unique case (i_cmd.vcap_sel)
                2'd1:    r_v[1] <= r_vrd;
                2'd2:    r_v[2] <= r_vrd;
                default: r_v[0] <= r_vrd;
            endcase
        end
    end

    // ---------------- accumulator store ----------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = sat_add(r_ard[k*ACC_W +: ACC_W], r_t[k]);
        end
        n_am_wd = i_cmd.am_zero ? '0 : {n_sum[2], n_sum[1], n_sum[0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.am_we) begin
            amem[n_am_a] <= n_am_wd;
        end
        r_ard <= amem[n_am_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.am_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------- deltas and products ----------------
    assign n_du1 = uvd(r_v[1][2*UV_W-1 -: UV_W], r_v[0][2*UV_W-1 -: UV_W]);
    assign n_dv1 = uvd(r_v[1][UV_W-1:0], r_v[0][UV_W-1:0]);
    assign n_du2 = uvd(r_v[2][2*UV_W-1 -: UV_W], r_v[0][2*UV_W-1 -: UV_W]);
    assign n_dv2 = uvd(r_v[2][UV_W-1:0], r_v[0][UV_W-1:0]);
    assign n_dp1 = pd(vpos(r_v[1], i_cmd.axis), vpos(r_v[0], i_cmd.axis));
    assign n_dp2 = pd(vpos(r_v[2], i_cmd.axis), vpos(r_v[0], i_cmd.axis));

    // det = du1*dv2 - dv1*du2 ; num = dp1*dv2 - dp2*dv1
    assign n_ma = i_cmd.prod_det ? DP_W'(n_du1) : n_dp1;
    assign n_mb = i_cmd.prod_det ? DP_W'(n_dv1) : n_dp2;
    assign n_mc = n_dv2;
    assign n_md = i_cmd.prod_det ? n_du2 : n_dv1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_pa <= n_ma * n_mc;
            r_pb <= n_mb * n_md;
        end
        if (i_cmd.diff_en) begin
            r_diff <= {r_pa[PRD_W-1], r_pa} - {r_pb[PRD_W-1], r_pb};
        end
        if (i_cmd.det_cap) begin
            r_det <= r_diff;
        end
        if (i_cmd.div_start && !i_cmd.div_norm) begin
            r_qneg <= r_diff[NUM_W-1] ^ r_det[NUM_W-1];
        end
    end

    assign n_num_abs = r_diff[NUM_W-1] ? NUM_W'(-r_diff) : r_diff;
    assign n_det_abs = r_det[NUM_W-1] ? NUM_W'(-r_det) : r_det;

    // ---------------- divider ----------------
    always_comb begin
        if (i_cmd.div_norm) begin
            n_dvd = {{(DIV_NW-NRM_W-FRAC_SH){1'b0}}, r_mag[i_cmd.axis][NRM_W-1:0],
                     {FRAC_SH{1'b0}}}
                    + {{(DIV_NW-ROOT_W+1){1'b0}}, n_len[ROOT_W-1:1]};
            n_dvs = {{(DIV_DW-ROOT_W){1'b0}}, n_len};
        end else begin
            n_dvd = {n_num_abs[DIV_NW-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
            n_dvs = n_det_abs[DIV_DW-1:0];
        end
    end

    vta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (n_div_done),
        .o_quot     (n_quot)
    );

    // tangent quotient saturates at 2^47-1
    assign n_qmag = (|n_quot[DIV_NW-1:ACC_W-1]) ? {(ACC_W-1){1'b1}} : n_quot[ACC_W-2:0];
    assign n_tval = r_qneg ? -$signed({1'b0, n_qmag}) : $signed({1'b0, n_qmag});
    assign n_cval = r_neg[i_cmd.axis] ? TAN_W'(-{1'b0, n_quot[TAN_W-2:0]})
                                      : {1'b0, n_quot[TAN_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.t_cap) begin
            r_t[i_cmd.axis] <= n_tval;
        end
    end

    // ---------------- read: magnitudes, normalize, squares ----------------
    assign n_mor = r_mag[0] | r_mag[1] | r_mag[2];
    assign n_hi  = |n_mor[ACC_W-1:NRM_W];
    assign n_lo  = ~|n_mor[ACC_W-1:NRM_W-1];
    assign n_sqm = (i_cmd.axis == AX_NONE) ? '0 : r_mag[i_cmd.axis][NRM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_cap) begin
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= !r_ok_a ? '0 :
                            r_ard[k*ACC_W + ACC_W-1] ? ACC_W'(-r_ard[k*ACC_W +: ACC_W])
                                                     : r_ard[k*ACC_W +: ACC_W];
                r_neg[k] <= r_ard[k*ACC_W + ACC_W-1];
            end
        end else if (i_cmd.norm_en) begin
            for (int k = 0; k < 3; k++) begin
                if (n_hi) begin
                    r_mag[k] <= r_mag[k] >> 1;
                end else if (n_lo) begin
                    r_mag[k] <= r_mag[k] << 1;
                end
            end
        end
        if (i_cmd.sq_clr) begin
            r_sqp  <= '0;
            r_ssum <= '0;
        end else if (i_cmd.sq_en) begin
            r_sqp  <= n_sqm * n_sqm;
            r_ssum <= r_ssum + SQ_W'(r_sqp);
        end
    end

    vta_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (r_ssum),
        .o_done  (n_sqrt_done),
        .o_root  (n_len)
    );

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_fire;
        end
        if (i_cmd.out_fire) begin
            r_out_index <= r_idx[0];
        end
        if (i_cmd.out_zero) begin
            for (int k = 0; k < 3; k++) begin
                r_tan[k] <= '0;
            end
            r_zl <= 1'b1;
        end else if (i_cmd.out_cap) begin
            r_tan[i_cmd.axis] <= n_cval;
            r_zl <= 1'b0;
        end
    end

    assign o_sts.ok_a      = r_ok_a;
    assign o_sts.ok_all    = r_ok_all;
    assign o_sts.clr_last  = (r_clr_addr == AW'(MAX_VERTICES-1));
    assign o_sts.det_zero  = (r_diff == '0);
    assign o_sts.div_done  = n_div_done;
    assign o_sts.sqrt_done = n_sqrt_done;
    assign o_sts.acc_zero  = (n_mor == '0);
    assign o_sts.norm_ok   = !n_hi && !n_lo;

    assign o_valid       = r_valid;
    assign o_out_index   = r_out_index;
    assign o_tan_x       = r_tan[0];
    assign o_tan_y       = r_tan[1];
    assign o_tan_z       = r_tan[2];
    assign o_zero_length = r_zl;

endmodule

// File: design/vta_ctrl.sv
// vta_ctrl: sequencing state machine for clear, load, triangle and read transactions.
// Depends on vta_pkg for the command and status structs.
module vta_ctrl import vta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LD,
        S_TR0, S_TR1, S_TR2, S_TR3,
        S_DPROD, S_DDIFF, S_DCHK,
        S_NPROD, S_NDIFF, S_NDIV, S_NWAIT,
        S_AR, S_AW,
        S_RD0, S_RD1, S_RCHK, S_NORM, S_SQ, S_SQRT, S_SWAIT, S_QDIV, S_QWAIT, S_OUT
    } t_state;

    t_state     r_state, n_state;
    t_axis      r_axis, n_axis;
    logic [1:0] r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_axis   <= AX_X;
            r_corner <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_corner <= n_corner;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_corner = r_corner;
        o_cmd    = '0;
        o_cmd.axis   = r_axis;
        o_cmd.corner = r_corner;
        unique case (r_state)
            S_CLR: begin
                o_cmd.am_we   = 1'b1;
                o_cmd.am_zero = 1'b1;
                o_cmd.am_clr  = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_corner    = 2'd0;
                    unique case (t_req'(i_req_type))
                        REQ_LOAD: n_state = S_LD;
                        REQ_TRI:  n_state = S_TR0;
                        REQ_READ: n_state = S_RD0;
                        REQ_NONE: n_state = S_IDLE;
                    endcase
                end
            end
            S_LD: begin
                o_cmd.vm_we = i_sts.ok_a;
                n_state     = S_IDLE;
            end
            S_TR0: begin
                o_cmd.vm_sel = 2'd0;
                n_state = i_sts.ok_all ? S_TR1 : S_IDLE;
            end
            S_TR1: begin
                o_cmd.vm_sel   = 2'd1;
                o_cmd.vcap_en  = 1'b1;
                o_cmd.vcap_sel = 2'd0;
                n_state = S_TR2;
            end
            S_TR2: begin
                o_cmd.vm_sel   = 2'd2;
                o_cmd.vcap_en  = 1'b1;
                o_cmd.vcap_sel = 2'd1;
                n_state = S_TR3;
            end
            S_TR3: begin
                o_cmd.vcap_en  = 1'b1;
                o_cmd.vcap_sel = 2'd2;
                n_state = S_DPROD;
            end
            S_DPROD: begin
                o_cmd.prod_en  = 1'b1;
                o_cmd.prod_det = 1'b1;
                n_state = S_DDIFF;
            end
            S_DDIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.det_cap = 1'b1;
                n_axis  = AX_X;
                n_state = i_sts.det_zero ? S_IDLE : S_NPROD;
            end
            S_NPROD: begin
                o_cmd.prod_en = 1'b1;
                n_state = S_NDIFF;
            end
            S_NDIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_NWAIT;
            end
            S_NWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.t_cap = 1'b1;
                    if (r_axis == AX_Z) begin
                        n_corner = 2'd0;
                        n_state  = S_AR;
                    end else begin
                        n_axis  = t_axis'(r_axis + 2'd1);
                        n_state = S_NPROD;
                    end
                end
            end
            S_AR: begin
                n_state = S_AW;
            end
            S_AW: begin
                // read-modify-write; next corner reads after this write lands
                o_cmd.am_we = 1'b1;
                if (r_corner == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_corner = r_corner + 2'd1;
                    n_state  = S_AR;
                end
            end
            S_RD0: begin
                o_cmd.am_we   = i_sts.ok_a;
                o_cmd.am_zero = 1'b1;
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.acc_cap = 1'b1;
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (i_sts.acc_zero) begin
                    o_cmd.out_zero = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm_en = 1'b1;
                o_cmd.sq_clr  = 1'b1;
                if (i_sts.norm_ok) begin
                    n_axis  = AX_X;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                // fourth pass drains the last square into the sum
                o_cmd.sq_en = 1'b1;
                if (r_axis == AX_NONE) begin
                    n_state = S_SQRT;
                end else begin
                    n_axis = t_axis'(r_axis + 2'd1);
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.sqrt_done) begin
                    n_axis  = AX_X;
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_norm  = 1'b1;
                n_state = S_QWAIT;
            end
            S_QWAIT: begin
                o_cmd.div_norm = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.out_cap = 1'b1;
                    if (r_axis == AX_Z) begin
                        n_state = S_OUT;
                    end else begin
                        n_axis  = t_axis'(r_axis + 2'd1);
                        n_state = S_QDIV;
                    end
                end
            end
            S_OUT: begin
                o_cmd.out_fire = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking bench for vertex_tangent_accumulator; a scoreboard class predicts
// the tangent of every read from its own vertex store. Depends on vta_pkg and the RTL.
module tb_top import vta_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VERTS      = 1024;
    localparam int RAND_ITEMS = 1250;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN      = 400;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
        logic signed [TAN_W-1:0] tz;
        logic                    zero_len;
    } tangent_t;

    class tangent_board;
        localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
        localparam longint ACC_LO = -ACC_HI - 1;
        int      px[VERTS], py[VERTS], pz[VERTS];
        shortint uu[VERTS], vv[VERTS];
        longint  sx[VERTS], sy[VERTS], sz[VERTS];
        tangent_t due[$];
        int errors, checked;

        function new();
            for (int i = 0; i < VERTS; i++) begin
                sx[i] = 0; sy[i] = 0; sz[i] = 0;
            end
            errors = 0; checked = 0;
        endfunction

        static function longint unsigned absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        // n * 2^14 / d, truncated, magnitude clamped to 2^47-1
        static function longint scaled_div(longint n, longint d);
            longint unsigned un, ud, q0, q;
            bit neg;
            neg = (n < 0) != (d < 0);
            un = absval(n); ud = absval(d);
            q0 = un / ud;
            if (q0 >= (64'd1 << 33)) q = ACC_HI;
            else begin
                q = (q0 << 14) + (((un % ud) << 14) / ud);
                if (q > ACC_HI) q = ACC_HI;
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        static function longint clamp_add(longint a, longint t);
            longint s;
            s = a + t;
            if (s > ACC_HI) return ACC_HI;
            if (s < ACC_LO) return ACC_LO;
            return s;
        endfunction

        static function longint unsigned root64(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'h4000_0000_0000_0000;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        static function logic [TAN_W-1:0] unit_comp(longint v, longint unsigned m,
                                                      longint unsigned len);
            longint unsigned q;
            q = (m * 16384 + len / 2) / len;
            return v < 0 ? -q[TAN_W-1:0] : q[TAN_W-1:0];
        endfunction

        function void add_face(int a, int b, int c);
            longint du1, dv1, du2, dv2, det, t[3];
            int cr[3];
            cr = '{a, b, c};
            du1 = longint'(uu[b]) - uu[a];
            dv1 = longint'(vv[b]) - vv[a];
            du2 = longint'(uu[c]) - uu[a];
            dv2 = longint'(vv[c]) - vv[a];
            det = du1 * dv2 - dv1 * du2;
            if (det == 0) return;
            t[0] = scaled_div((longint'(px[b]) - px[a]) * dv2 -
                              (longint'(px[c]) - px[a]) * dv1, det);
            t[1] = scaled_div((longint'(py[b]) - py[a]) * dv2 -
                              (longint'(py[c]) - py[a]) * dv1, det);
            t[2] = scaled_div((longint'(pz[b]) - pz[a]) * dv2 -
                              (longint'(pz[c]) - pz[a]) * dv1, det);
            foreach (cr[k]) begin
                sx[cr[k]] = clamp_add(sx[cr[k]], t[0]);
                sy[cr[k]] = clamp_add(sy[cr[k]], t[1]);
                sz[cr[k]] = clamp_add(sz[cr[k]], t[2]);
            end
        endfunction

        function void note(t_req rt, int idx, int x, int y, int z, shortint u, shortint v,
                           int c1, int c2);
            tangent_t e;
            longint ax, ay, az;
            longint unsigned mx, my, mz, m, len;
            case (rt)
                REQ_LOAD: begin
                    px[idx] = x; py[idx] = y; pz[idx] = z; uu[idx] = u; vv[idx] = v;
                end
                REQ_TRI: add_face(idx, c1, c2);
                REQ_READ: begin
                    ax = sx[idx]; ay = sy[idx]; az = sz[idx];
                    sx[idx] = 0; sy[idx] = 0; sz[idx] = 0;
                    e.index = IDX_W'(idx);
                    e.tx = 0; e.ty = 0; e.tz = 0; e.zero_len = 1;
                    if (ax != 0 || ay != 0 || az != 0) begin
                        mx = absval(ax); my = absval(ay); mz = absval(az);
                        m = mx > my ? mx : my;
                        if (mz > m) m = mz;
                        while (m < (64'd1 << 30)) begin
                            mx <<= 1; my <<= 1; mz <<= 1; m <<= 1;
                        end
                        while (m >= (64'd1 << 31)) begin
                            mx >>= 1; my >>= 1; mz >>= 1; m >>= 1;
                        end
                        len = root64(mx * mx + my * my + mz * mz);
                        e.tx = unit_comp(ax, mx, len);
                        e.ty = unit_comp(ay, my, len);
                        e.tz = unit_comp(az, mz, len);
                        e.zero_len = 0;
                    end
                    due = {due, e};
                end
                default: ;
            endcase
        endfunction

        function void check(tangent_t got);
            tangent_t e;
            checked++;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected tangent for vertex %0d", got.index);
                return;
            end
            e = due.pop_front();
            if (got.index !== e.index || got.tx !== e.tx || got.ty !== e.ty ||
                got.tz !== e.tz || got.zero_len !== e.zero_len) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: got idx %0d t=(%0d,%0d,%0d) z=%b, ",
                              "want idx %0d t=(%0d,%0d,%0d) z=%b"},
                             got.index, got.tx, got.ty, got.tz, got.zero_len,
                             e.index, e.tx, e.ty, e.tz, e.zero_len);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_req_type = '0;
    logic [IDX_W-1:0]        i_vert_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [UV_W-1:0]  i_uv_u = '0, i_uv_v = '0;
    logic [IDX_W-1:0]        i_corner_one = '0, i_corner_two = '0;
    logic                    o_valid;
    logic [IDX_W-1:0]        o_out_index;
    logic signed [TAN_W-1:0] o_tan_x, o_tan_y, o_tan_z;
    logic                    o_zero_length;

    tangent_board board = new();
    bit   loaded[VERTS];
    int   loaded_list[$];
    int   idle_pct;
    int   cycles, n_load, n_tri, n_read;

    vertex_tangent_accumulator uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid)
            board.check('{o_out_index, o_tan_x, o_tan_y, o_tan_z, o_zero_length});

    task automatic send(t_req rt, int idx, int x, int y, int z, int u, int v, int c1, int c2);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = rt; i_vert_index = IDX_W'(idx);
        i_pos_x = x; i_pos_y = y; i_pos_z = z;
        i_uv_u = UV_W'(u); i_uv_v = UV_W'(v);
        i_corner_one = IDX_W'(c1); i_corner_two = IDX_W'(c2);
        do @(posedge i_clk); while (busy);
        board.note(rt, idx, x, y, z, shortint'(u), shortint'(v), c1, c2);
        case (rt)
            REQ_LOAD: begin
                n_load++;
                if (!loaded[idx]) loaded_list = {loaded_list, idx};
                loaded[idx] = 1;
            end
            REQ_TRI:  n_tri++;
            REQ_READ: n_read++;
            default: ;
        endcase
    endtask

    function automatic int pick_index();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, VERTS - 1)
                                           : $urandom_range(0, 31);
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return ($urandom_range(0, 4095) - 2048) <<< 12;
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    function automatic int rand_uv();
        return $urandom_range(0, 1) ? $urandom_range(0, 65535) - 32768
                                    : $urandom_range(0, 2000) - 1000;
    endfunction

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial begin
        int kind, phase;
        cycles = 0; n_load = 0; n_tri = 0; n_read = 0; idle_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, zero determinant, repeated corner, saturation, clear on read
        send(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_LOAD, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, 0, 0, 0);
        send(REQ_LOAD, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32767, 0, 0);
        send(REQ_LOAD, 3, 12345, -678, 9, 0, 0, 0, 0);
        send(REQ_LOAD, 4, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0, 0, 0);
        send(REQ_LOAD, 5, 32'h8000_0000, 32'h7FFF_FFFF, -1, 0, 1, 0, 0);
        send(REQ_LOAD, 1023, 32'h4000_0000, -5, 7, -32768, -32768, 0, 0);
        send(REQ_TRI, 0, 0, 0, 0, 0, 0, 1, 2);
        send(REQ_TRI, 0, 0, 0, 0, 0, 0, 0, 1);        // repeated corner
        send(REQ_TRI, 0, 0, 0, 0, 0, 0, 1, 3);        // degenerate uv
        send(REQ_TRI, 1023, 0, 0, 0, 0, 0, 1, 2);
        repeat (5) send(REQ_TRI, 0, 0, 0, 0, 0, 0, 4, 5);   // drives into saturation
        send(REQ_TRI, 0, 0, 0, 0, 0, 0, 5, 4);
        send(REQ_NONE, 1023, -1, -1, -1, -1, -1, 1023, 1023);
        send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0);       // cleared entry
        send(REQ_READ, 4, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 5, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 7, 0, 0, 0, 0, 0, 0, 0);       // never touched

        // random: mostly loads/triangles/reads over a hot set; the receiver
        // cannot stall, so phases only vary sender idling
        for (int n = 0; n < RAND_ITEMS; ) begin
            phase = n * 4 / RAND_ITEMS;
            idle_pct = (phase == 1) ? 64 : (phase == 3) ? 27 : 0;
            if (phase == 2) idle_pct = $urandom_range(0, 1) ? 64 : 0;
            kind = $urandom_range(0, 99);
            if (kind < 30)
                send(REQ_LOAD, pick_index(), rand_pos(), rand_pos(), rand_pos(),
                     rand_uv(), rand_uv(), $urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (kind < 70)
                send(REQ_TRI, any_loaded(), $urandom, $urandom, $urandom,
                     $urandom, $urandom, any_loaded(), any_loaded());
            else if (kind < 96)
                send(REQ_READ, pick_index(), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else begin
                send(REQ_NONE, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
                continue;
            end
            n++;
        end
        @(negedge i_clk);
        start = 1'b0;

        while (board.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Covered %0d vertex loads, %0d triangles and %0d tangent reads;",
                 n_load, n_tri, n_read);
        $display("%0d tangents checked, %0d mismatches, %0d cycles.",
                 board.checked, board.errors, cycles);
        if (board.errors == 0 && board.due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
design/vta_pkg.sv
design/vta_div.sv
design/vta_isqrt.sv
design/vta_dpath.sv
design/vta_ctrl.sv
design/vertex_tangent_accumulator.sv
dv/tb_top.sv
